FILE: hdl/heading_pose_integrator_top_macros.svh
// Assertion macros for the heading pose integrator.
// Used by heading_pose_integrator_top; each macro expects clk and rst_n in scope.
`ifndef HEADING_POSE_INTEGRATOR_TOP_MACROS_SVH
`define HEADING_POSE_INTEGRATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPI_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPI_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hpi_pkg.sv
// Shared constants, types and elaboration-time functions of the heading pose integrator.
// Has no dependencies; all block files but hpi_cell and the macro header use it by scoped names.
`default_nettype none

package hpi_pkg;

    // Default number of index bits of the full-circle sine table.
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field widths.
    localparam int YAW_W   = 16;
    localparam int PITCH_W = 15;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 16;
    localparam int SINE_W  = 16;
    localparam int OFF_W   = 16;

    // Angles in 1/128 degree.
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int EIGHTH_TURN  = 5760;

    // Division by 45 as a reciprocal multiply: exact for every value below 2^26 / 41,
    // which covers the table index computation up to 14 index bits.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 21;
    localparam int RECIP_MULT  = 1491309;

    // Pi in Q30 for the table generator.
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int SERIES_TERMS = 10;

    // Angle stage results handed to the pipeline.
    typedef struct packed {
        logic [YAW_W-1:0]        yaw;
        logic [PITCH_W-1:0]      pitch;
        logic signed [OFF_W-1:0] off;
        logic                    move;
    } angle_t;

    // Divide a Taylor term by (2n)(2n+1) for term number n.
    function automatic longint unsigned series_div(input longint unsigned t, input int n);
        longint unsigned q;
        unique case (n)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            8:       q = t / 64'd272;
            9:       q = t / 64'd342;
            default: q = t / 64'd420;
        endcase
        return q;
    endfunction

    // Sine of a quarter-circle table entry r, with 2^(bits-2) entries per quarter, in Q1.15.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r,
                                                       input int unsigned bits);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        int              n;
        theta = (PI_Q30 * 64'(r)) >> (bits - 1);
        x2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (n = 1; n <= SERIES_TERMS; n++) begin
            term = (term * x2) >> 30;
            term = series_div(term, n);
            if (n[0]) begin
                sum = sum - longint'(term);
            end
            else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hpi_cell.sv
// One pipeline cell: a valid flag and a payload register with elastic handshake.
// Generic over the payload type; no package dependency.
`default_nettype none

module hpi_cell #(
    parameter type data_t = logic
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire data_t up_data,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output data_t      dn_data
);

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;

    // The cell takes a new transfer when empty or when its content leaves this cycle.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each incoming transfer.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

FILE: hdl/hpi_angle.sv
// Yaw and pitch state with wrap and clamp, and heading offset selection from move signs.
// Depends on hpi_pkg for widths, turn constants and the angle_t result type.
`default_nettype none

module hpi_angle (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic signed [16:0]                  pitch_delta,
    input  wire logic signed [16:0]                  yaw_delta,
    input  wire logic signed [1:0]                   forward_sign,
    input  wire logic signed [1:0]                   right_sign,
    input  wire logic signed [hpi_pkg::SPEED_W-1:0]  step_speed,
    output hpi_pkg::angle_t                          angle
);

    localparam logic signed [18:0] YAW_FULL   = 19'(hpi_pkg::FULL_TURN);
    localparam logic signed [17:0] PITCH_MAX  = 18'(hpi_pkg::HALF_TURN);
    localparam logic signed [hpi_pkg::OFF_W-1:0] OFF_EIGHTH  =
        hpi_pkg::OFF_W'(hpi_pkg::EIGHTH_TURN);
    localparam logic signed [hpi_pkg::OFF_W-1:0] OFF_QUARTER =
        hpi_pkg::OFF_W'(hpi_pkg::QUARTER_TURN);
    localparam logic signed [hpi_pkg::OFF_W-1:0] OFF_HALF    =
        hpi_pkg::OFF_W'(hpi_pkg::HALF_TURN);

    logic [hpi_pkg::YAW_W-1:0]   yaw_reg;
    logic [hpi_pkg::YAW_W-1:0]   yaw_next;
    logic [hpi_pkg::PITCH_W-1:0] pitch_reg;
    logic [hpi_pkg::PITCH_W-1:0] pitch_next;

    logic signed [18:0] yaw_sum;
    logic signed [18:0] yaw_up;
    logic signed [18:0] yaw_down;
    logic signed [17:0] pitch_sum;
    logic               fwd_pos;
    logic               fwd_neg;
    logic               rgt_pos;
    logic               rgt_neg;
    logic               move;
    logic signed [hpi_pkg::OFF_W-1:0] off;

    // Yaw: one wrap in each direction, then a clamp to the full turn.
    always_comb
    begin
        yaw_sum  = $signed({3'b000, yaw_reg}) + 19'(yaw_delta);
        yaw_up   = (yaw_sum < 0) ? yaw_sum + YAW_FULL : yaw_sum;
        yaw_down = (yaw_up > YAW_FULL) ? yaw_up - YAW_FULL : yaw_up;
        priority if (yaw_down < 0)
        begin
            yaw_next = '0;
        end
        else if (yaw_down > YAW_FULL)
        begin
            yaw_next = YAW_FULL[hpi_pkg::YAW_W-1:0];
        end
        else
        begin
            yaw_next = yaw_down[hpi_pkg::YAW_W-1:0];
        end
    end

    // Pitch: clamp to the half turn.
    always_comb
    begin
        pitch_sum = $signed({3'b000, pitch_reg}) + 18'(pitch_delta);
        priority if (pitch_sum < 0)
        begin
            pitch_next = '0;
        end
        else if (pitch_sum > PITCH_MAX)
        begin
            pitch_next = PITCH_MAX[hpi_pkg::PITCH_W-1:0];
        end
        else
        begin
            pitch_next = pitch_sum[hpi_pkg::PITCH_W-1:0];
        end
    end

    // Heading offset from the move signs; any pattern with the top bit set is negative.
    always_comb
    begin
        fwd_pos = (forward_sign == 2'sb01);
        fwd_neg = forward_sign[1];
        rgt_pos = (right_sign == 2'sb01);
        rgt_neg = right_sign[1];
        move    = 1'b1;
        priority if (fwd_pos)
        begin
            off = rgt_pos ? OFF_EIGHTH : (rgt_neg ? -OFF_EIGHTH : '0);
        end
        else if (fwd_neg)
        begin
            off = OFF_HALF + (rgt_pos ? -OFF_EIGHTH : (rgt_neg ? OFF_EIGHTH : '0));
        end
        else
        begin
            off  = rgt_pos ? OFF_QUARTER : -OFF_QUARTER;
            move = rgt_pos || rgt_neg;
        end
    end

    // Angle state, updated on each accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else if (accept)
        begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    assign angle.yaw   = yaw_next;
    assign angle.pitch = pitch_next;
    assign angle.off   = off;
    assign angle.move  = move && (step_speed != '0);

endmodule

`default_nettype wire

FILE: hdl/hpi_qsine.sv
// Sine lookup from a quarter-wave constant table mirrored to the full circle.
// Depends on hpi_pkg for the table generator function and the sine width.
`default_nettype none

module hpi_qsine #(
    parameter int SINE_TABLE_BITS = hpi_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic [SINE_TABLE_BITS-1:0]        idx,
    output logic signed [hpi_pkg::SINE_W-1:0]      sine
);

    localparam int QW     = SINE_TABLE_BITS - 2;
    localparam int QDEPTH = (2 ** QW) + 1;
    localparam int TW     = QW + 1;

    logic [hpi_pkg::SINE_W-1:0] qtab [QDEPTH];
    logic [1:0]                 quad;
    logic [QW-1:0]              rem;
    logic [TW-1:0]              tidx;
    logic [hpi_pkg::SINE_W-1:0] mag;

    // Quarter-wave table, including the entry at a quarter turn.
    for (genvar r = 0; r < QDEPTH; r++)
    begin : g_tab
        assign qtab[r] = hpi_pkg::quarter_sine(r, SINE_TABLE_BITS);
    end

    // Odd quadrants read the table backward; the lower half of the circle negates.
    assign quad = idx[SINE_TABLE_BITS-1 -: 2];
    assign rem  = idx[QW-1:0];
    assign tidx = quad[0] ? (TW'(2 ** QW) - {1'b0, rem}) : {1'b0, rem};
    assign mag  = qtab[tidx];
    assign sine = quad[1] ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

FILE: hdl/heading_pose_integrator_top.sv
// Pipeline: six cells, the first loaded by the input transfer and the last presenting its
// result. Throughput: one item per cycle while out_ready accepts results; the only feedback
// loops are the yaw/pitch update in the angle stage and the saturating position add.
// Reset: asynchronous, active low; clears yaw, pitch, position and all cell valid flags.
// The sine table is constant logic, so no clearing pass follows reset.
// Depends on hpi_pkg, hpi_cell, hpi_angle, hpi_qsine and the assertion macro header.
`default_nettype none

`include "heading_pose_integrator_top_macros.svh"

module heading_pose_integrator_top #(
    parameter int SINE_TABLE_BITS = hpi_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [16:0]                  pitch_delta,
    input  wire logic signed [16:0]                  yaw_delta,
    input  wire logic signed [1:0]                   forward_sign,
    input  wire logic signed [1:0]                   right_sign,
    input  wire logic signed [hpi_pkg::SPEED_W-1:0]  step_speed,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [hpi_pkg::POS_W-1:0]         pos_x_out,
    output logic signed [hpi_pkg::POS_W-1:0]         pos_y_out,
    output logic [hpi_pkg::YAW_W-1:0]                yaw_out,
    output logic [hpi_pkg::PITCH_W-1:0]              pitch_out,
    output logic                                     pos_saturated
);

    localparam int IDX_W = SINE_TABLE_BITS;
    localparam int U_W   = SINE_TABLE_BITS + 6;
    localparam int P_W   = U_W + hpi_pkg::RECIP_W;
    localparam int QUARTER_IDX = 2 ** (SINE_TABLE_BITS - 2);
    localparam int SUM_W = hpi_pkg::POS_W + 2;

    localparam logic signed [18:0] HEAD_FULL = 19'(hpi_pkg::FULL_TURN);
    localparam logic signed [18:0] HEAD_TWO  = 19'(2 * hpi_pkg::FULL_TURN);
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-64'sd2147483648);

    typedef struct packed {
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic signed [hpi_pkg::OFF_W-1:0]    off;
        logic                                move;
        logic signed [hpi_pkg::SPEED_W-1:0]  speed;
    } s0_t;

    typedef struct packed {
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic                                move;
        logic signed [hpi_pkg::SPEED_W-1:0]  speed;
        logic [U_W-1:0]                      u;
    } s1_t;

    typedef struct packed {
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic                                move;
        logic signed [hpi_pkg::SPEED_W-1:0]  speed;
        logic [P_W-1:0]                      prod;
    } s2_t;

    typedef struct packed {
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic                                move;
        logic signed [hpi_pkg::SPEED_W-1:0]  speed;
        logic signed [hpi_pkg::SINE_W-1:0]   sin_v;
        logic signed [hpi_pkg::SINE_W-1:0]   cos_v;
    } s3_t;

    typedef struct packed {
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic                                move;
        logic signed [hpi_pkg::POS_W-1:0]    px;
        logic signed [hpi_pkg::POS_W-1:0]    py;
    } s4_t;

    typedef struct packed {
        logic signed [hpi_pkg::POS_W-1:0]    pos_x;
        logic signed [hpi_pkg::POS_W-1:0]    pos_y;
        logic [hpi_pkg::YAW_W-1:0]           yaw;
        logic [hpi_pkg::PITCH_W-1:0]         pitch;
        logic                                sat;
    } s5_t;

    hpi_pkg::angle_t angle;

    s0_t s0_in, s0_out;
    s1_t s1_in, s1_out;
    s2_t s2_in, s2_out;
    s3_t s3_in, s3_out;
    s4_t s4_in, s4_out;
    s5_t s5_in, s5_out;

    logic c0_valid, c1_valid, c2_valid, c3_valid, c4_valid;
    logic c1_ready, c2_ready, c3_ready, c4_ready, c5_ready;

    logic signed [18:0]               head_raw;
    logic [hpi_pkg::YAW_W-1:0]        heading;
    logic [hpi_pkg::YAW_W+IDX_W-1:0]  head_scaled;
    logic [IDX_W-1:0]                 sin_idx;
    logic [IDX_W-1:0]                 cos_idx;
    logic signed [hpi_pkg::SINE_W-1:0] sin_val;
    logic signed [hpi_pkg::SINE_W-1:0] cos_val;

    logic signed [hpi_pkg::POS_W:0]   rx_full;
    logic signed [hpi_pkg::POS_W:0]   ry_full;
    logic signed [SUM_W-1:0]          sum_x;
    logic signed [SUM_W-1:0]          sum_y;
    logic signed [hpi_pkg::POS_W-1:0] pos_x_reg;
    logic signed [hpi_pkg::POS_W-1:0] pos_x_next;
    logic signed [hpi_pkg::POS_W-1:0] pos_y_reg;
    logic signed [hpi_pkg::POS_W-1:0] pos_y_next;
    logic                             sat_x;
    logic                             sat_y;
    logic                             pos_load;

    // Angle state and heading offset, updated on each input transfer.
    hpi_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_valid && in_ready),
        .pitch_delta  (pitch_delta),
        .yaw_delta    (yaw_delta),
        .forward_sign (forward_sign),
        .right_sign   (right_sign),
        .step_speed   (step_speed),
        .angle        (angle)
    );

    assign s0_in.yaw   = angle.yaw;
    assign s0_in.pitch = angle.pitch;
    assign s0_in.off   = angle.off;
    assign s0_in.move  = angle.move;
    assign s0_in.speed = step_speed;

    hpi_cell #(.data_t(s0_t)) u_cell0 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (in_valid), .up_ready (in_ready), .up_data (s0_in),
        .dn_valid (c0_valid), .dn_ready (c1_ready), .dn_data (s0_out)
    );

    // Heading angle reduced into one turn, then scaled by table size over 1024.
    always_comb
    begin
        head_raw = 19'(s0_out.off) - $signed({3'b000, s0_out.yaw}) + HEAD_TWO;
        priority if (head_raw >= HEAD_TWO)
        begin
            heading = hpi_pkg::YAW_W'(head_raw - HEAD_TWO);
        end
        else if (head_raw >= HEAD_FULL)
        begin
            heading = hpi_pkg::YAW_W'(head_raw - HEAD_FULL);
        end
        else
        begin
            heading = hpi_pkg::YAW_W'(head_raw);
        end
        head_scaled = {heading, {IDX_W{1'b0}}};
    end

    assign s1_in.yaw   = s0_out.yaw;
    assign s1_in.pitch = s0_out.pitch;
    assign s1_in.move  = s0_out.move;
    assign s1_in.speed = s0_out.speed;
    assign s1_in.u     = head_scaled[hpi_pkg::YAW_W+IDX_W-1:10];

    hpi_cell #(.data_t(s1_t)) u_cell1 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (c0_valid), .up_ready (c1_ready), .up_data (s1_in),
        .dn_valid (c1_valid), .dn_ready (c2_ready), .dn_data (s1_out)
    );

    // Division by 45 as a reciprocal multiply.
    assign s2_in.yaw   = s1_out.yaw;
    assign s2_in.pitch = s1_out.pitch;
    assign s2_in.move  = s1_out.move;
    assign s2_in.speed = s1_out.speed;
    assign s2_in.prod  = P_W'(s1_out.u) * P_W'(hpi_pkg::RECIP_MULT);

    hpi_cell #(.data_t(s2_t)) u_cell2 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (c1_valid), .up_ready (c2_ready), .up_data (s2_in),
        .dn_valid (c2_valid), .dn_ready (c3_ready), .dn_data (s2_out)
    );

    // Table index, and the cosine a quarter turn further on.
    assign sin_idx = s2_out.prod[hpi_pkg::RECIP_SHIFT +: IDX_W];
    assign cos_idx = sin_idx + IDX_W'(QUARTER_IDX);

    hpi_qsine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin (
        .idx  (sin_idx),
        .sine (sin_val)
    );

    hpi_qsine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos (
        .idx  (cos_idx),
        .sine (cos_val)
    );

    assign s3_in.yaw   = s2_out.yaw;
    assign s3_in.pitch = s2_out.pitch;
    assign s3_in.move  = s2_out.move;
    assign s3_in.speed = s2_out.speed;
    assign s3_in.sin_v = sin_val;
    assign s3_in.cos_v = cos_val;

    hpi_cell #(.data_t(s3_t)) u_cell3 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (c2_valid), .up_ready (c3_ready), .up_data (s3_in),
        .dn_valid (c3_valid), .dn_ready (c4_ready), .dn_data (s3_out)
    );

    // Speed times sine and cosine, Q9.23.
    assign s4_in.yaw   = s3_out.yaw;
    assign s4_in.pitch = s3_out.pitch;
    assign s4_in.move  = s3_out.move;
    assign s4_in.px    = hpi_pkg::POS_W'(s3_out.speed) * hpi_pkg::POS_W'(s3_out.sin_v);
    assign s4_in.py    = hpi_pkg::POS_W'(s3_out.speed) * hpi_pkg::POS_W'(s3_out.cos_v);

    hpi_cell #(.data_t(s4_t)) u_cell4 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (c3_valid), .up_ready (c4_ready), .up_data (s4_in),
        .dn_valid (c4_valid), .dn_ready (c5_ready), .dn_data (s4_out)
    );

    // Round to Q16.16 (ties upward) and add to the position with saturation.
    always_comb
    begin
        rx_full = 33'(s4_out.px) + 33'sd64;
        ry_full = 33'(s4_out.py) + 33'sd64;
        sum_x   = SUM_W'(pos_x_reg) + SUM_W'($signed(rx_full[hpi_pkg::POS_W:7]));
        sum_y   = SUM_W'(pos_y_reg) + SUM_W'($signed(ry_full[hpi_pkg::POS_W:7]));
        sat_x   = 1'b0;
        sat_y   = 1'b0;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (s4_out.move)
        begin
            priority if (sum_x > POS_MAX)
            begin
                pos_x_next = hpi_pkg::POS_W'(POS_MAX);
                sat_x      = 1'b1;
            end
            else if (sum_x < POS_MIN)
            begin
                pos_x_next = hpi_pkg::POS_W'(POS_MIN);
                sat_x      = 1'b1;
            end
            else
            begin
                pos_x_next = hpi_pkg::POS_W'(sum_x);
            end
            priority if (sum_y > POS_MAX)
            begin
                pos_y_next = hpi_pkg::POS_W'(POS_MAX);
                sat_y      = 1'b1;
            end
            else if (sum_y < POS_MIN)
            begin
                pos_y_next = hpi_pkg::POS_W'(POS_MIN);
                sat_y      = 1'b1;
            end
            else
            begin
                pos_y_next = hpi_pkg::POS_W'(sum_y);
            end
        end
    end

    assign pos_load = c4_valid && c5_ready;

    // Position state, advanced as each item enters the output cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (pos_load)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign s5_in.pos_x = pos_x_next;
    assign s5_in.pos_y = pos_y_next;
    assign s5_in.yaw   = s4_out.yaw;
    assign s5_in.pitch = s4_out.pitch;
    assign s5_in.sat   = sat_x || sat_y;

    // Output cell: holds a finished result until out_ready takes it; items behind fill the free cells.
    hpi_cell #(.data_t(s5_t)) u_cell5 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (c4_valid), .up_ready (c5_ready), .up_data (s5_in),
        .dn_valid (out_valid), .dn_ready (out_ready), .dn_data (s5_out)
    );

    assign pos_x_out     = s5_out.pos_x;
    assign pos_y_out     = s5_out.pos_y;
    assign yaw_out       = s5_out.yaw;
    assign pitch_out     = s5_out.pitch;
    assign pos_saturated = s5_out.sat;

    // Checks on the block's own logic.
    `HPI_CHECK_NOW(a_pos_tracks_out, out_valid,
        (pos_x_reg == pos_x_out) && (pos_y_reg == pos_y_out),
        "position state differs from the presented result")
    `HPI_CHECK_NOW(a_sat_at_bound, out_valid && pos_saturated,
        (pos_x_out == 32'sh7FFFFFFF) || (pos_x_out == 32'sh80000000) ||
        (pos_y_out == 32'sh7FFFFFFF) || (pos_y_out == 32'sh80000000),
        "saturation flagged with no coordinate at a bound")
    `HPI_CHECK_NEXT(a_still_no_sat, pos_load && !s4_out.move,
        !pos_saturated && $stable(pos_x_reg) && $stable(pos_y_reg),
        "item without motion changed the position")
    `HPI_CHECK_NOW(a_angle_range, out_valid,
        (yaw_out <= 16'd46080) && (pitch_out <= 15'd23040),
        "angle result outside its range")

endmodule

`default_nettype wire

FILE: sim/heading_pose_integrator_top_tb.sv
// Self-checking testbench for heading_pose_integrator_top: directed corners, position bound runs
// and random motion commands, with every result checked against an in-bench pose predictor.
// Depends on hpi_pkg and the heading_pose_integrator_top RTL.
`default_nettype none

module heading_pose_integrator_top_tb;

    localparam int LUT_BITS     = hpi_pkg::SINE_TABLE_BITS_DEF;
    localparam int LUT_N        = 1 << LUT_BITS;
    localparam int IDLE_PCT     = 34;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 1000;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    // Move sign codes; the pattern 10 is the odd negative code.
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [1:0] SIGN_M2   = 2'sb10;

    localparam logic signed [15:0] SPEED_MAX = 16'sd32767;
    localparam logic signed [15:0] SPEED_MIN = -16'sd32768;

    typedef struct {
        logic signed [hpi_pkg::POS_W-1:0] x;
        logic signed [hpi_pkg::POS_W-1:0] y;
        logic [hpi_pkg::YAW_W-1:0]        yaw;
        logic [hpi_pkg::PITCH_W-1:0]      pitch;
        logic                             sat;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [16:0] pitch_delta = '0;
    logic signed [16:0] yaw_delta = '0;
    logic signed [1:0] forward_sign = '0;
    logic signed [1:0] right_sign = '0;
    logic signed [hpi_pkg::SPEED_W-1:0] step_speed = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [hpi_pkg::POS_W-1:0] pos_x_out;
    logic signed [hpi_pkg::POS_W-1:0] pos_y_out;
    logic [hpi_pkg::YAW_W-1:0] yaw_out;
    logic [hpi_pkg::PITCH_W-1:0] pitch_out;
    logic pos_saturated;

    // Predictor state and the poses still owed by the block.
    int sine_lut[LUT_N];
    int yaw_now = 0;
    int pitch_now = 0;
    int pos_x_now = 0;
    int pos_y_now = 0;
    pose_t pose_queue[$];
    int err_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;

    heading_pose_integrator_top #(
        .SINE_TABLE_BITS(LUT_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pitch_delta(pitch_delta),
        .yaw_delta(yaw_delta),
        .forward_sign(forward_sign),
        .right_sign(right_sign),
        .step_speed(step_speed),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pos_x_out(pos_x_out),
        .pos_y_out(pos_y_out),
        .yaw_out(yaw_out),
        .pitch_out(pitch_out),
        .pos_saturated(pos_saturated)
    );

    // Clock with an 8 unit period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit in case the block stops moving.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("heading_pose_integrator_top_tb: errors");
            $finish;
        end
    end

    // The result side stalls at random except during steady stretches.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Q1.15 sine of quarter-circle entry r, using a Q30 Taylor series.
    function automatic int quarter_sine_q15(input int unsigned r);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint v;
        int n;
        theta = hpi_pkg::PI_Q30 * 64'(r) / 64'(2 * (LUT_N / 4));
        x2 = (theta * theta) >> 30;
        term = theta;
        sum = longint'(theta);
        for (n = 1; n <= 10; n++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum + 16384) / 32768;
        if (v > 32767)
            v = 32767;
        return int'(v);
    endfunction

    // Advances the predicted pose by one motion command and returns the expected result.
    function automatic pose_t predict_pose(input logic signed [16:0] dp,
                                           input logic signed [16:0] dy,
                                           input logic signed [1:0] fwd,
                                           input logic signed [1:0] rgt,
                                           input logic signed [15:0] spd);
        int y;
        int p;
        int off;
        int a;
        int idx;
        int s;
        int c;
        bit move;
        longint nx;
        longint ny;
        pose_t r;

        // Yaw wraps once, then clamps; pitch only clamps.
        y = yaw_now + int'(dy);
        if (y < 0)
            y += hpi_pkg::FULL_TURN;
        if (y > hpi_pkg::FULL_TURN)
            y -= hpi_pkg::FULL_TURN;
        if (y < 0)
            y = 0;
        if (y > hpi_pkg::FULL_TURN)
            y = hpi_pkg::FULL_TURN;
        yaw_now = y;

        p = pitch_now + int'(dp);
        if (p < 0)
            p = 0;
        if (p > hpi_pkg::HALF_TURN)
            p = hpi_pkg::HALF_TURN;
        pitch_now = p;

        // Heading offset from the two move signs.
        move = 1'b1;
        if (fwd > 0)
            off = (rgt > 0) ? hpi_pkg::EIGHTH_TURN :
                  ((rgt < 0) ? -hpi_pkg::EIGHTH_TURN : 0);
        else if (fwd < 0)
            off = hpi_pkg::HALF_TURN + ((rgt > 0) ? -hpi_pkg::EIGHTH_TURN :
                  ((rgt < 0) ? hpi_pkg::EIGHTH_TURN : 0));
        else
        begin
            off = (rgt > 0) ? hpi_pkg::QUARTER_TURN : -hpi_pkg::QUARTER_TURN;
            if (rgt == 0)
                move = 1'b0;
        end

        // Step along the heading with rounding and saturation at the 32-bit bounds.
        r.sat = 1'b0;
        if (move && spd != 0)
        begin
            a = (off - y + 2 * hpi_pkg::FULL_TURN) % hpi_pkg::FULL_TURN;
            idx = int'((longint'(a) << LUT_BITS) / hpi_pkg::FULL_TURN) & (LUT_N - 1);
            s = sine_lut[idx];
            c = sine_lut[(idx + LUT_N / 4) & (LUT_N - 1)];
            nx = longint'(pos_x_now) + ((longint'(spd) * s + 64) >>> 7);
            ny = longint'(pos_y_now) + ((longint'(spd) * c + 64) >>> 7);
            if (nx > POS_MAX)
            begin
                nx = POS_MAX;
                r.sat = 1'b1;
            end
            if (nx < POS_MIN)
            begin
                nx = POS_MIN;
                r.sat = 1'b1;
            end
            if (ny > POS_MAX)
            begin
                ny = POS_MAX;
                r.sat = 1'b1;
            end
            if (ny < POS_MIN)
            begin
                ny = POS_MIN;
                r.sat = 1'b1;
            end
            pos_x_now = int'(nx);
            pos_y_now = int'(ny);
        end

        r.x = pos_x_now;
        r.y = pos_y_now;
        r.yaw = yaw_now[hpi_pkg::YAW_W-1:0];
        r.pitch = pitch_now[hpi_pkg::PITCH_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Sends one motion command, then records its predicted pose once the transfer happens.
    task automatic send_cmd(input logic signed [16:0] dp, input logic signed [16:0] dy,
                            input logic signed [1:0] fwd, input logic signed [1:0] rgt,
                            input logic signed [15:0] spd);
        bit taken;
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pitch_delta <= dp;
        yaw_delta <= dy;
        forward_sign <= fwd;
        right_sign <= rgt;
        step_speed <= spd;
        taken = 1'b0;
        // Ready is sampled mid-cycle, where it is stable until the next edge.
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        pose_queue.push_back(predict_pose(dp, dy, fwd, rgt, spd));
    endtask

    // Angle delta: mostly small, sometimes anywhere in range, rarely beyond it.
    function automatic logic signed [16:0] rand_angle_delta();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 17'(int'($urandom_range(0, 4000)) - 2000);
        else if (pick < 90)
            return 17'(int'($urandom_range(0, 2 * hpi_pkg::FULL_TURN)) - hpi_pkg::FULL_TURN);
        else if (pick < 95)
            return ($urandom_range(0, 1) == 0) ? 17'sd65535 : -17'sd65536;
        else
            return 17'($urandom());
    endfunction

    // Each result is checked mid-cycle against the oldest predicted pose.
    always @(negedge clk)
    begin : check_results
        pose_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pose_queue.size() == 0)
            begin
                $error("result with no pose pending: x=0x%0h y=0x%0h", pos_x_out, pos_y_out);
                err_count++;
            end
            else
            begin
                want = pose_queue.pop_front();
                check_field("pos_x_out", want.x, pos_x_out);
                check_field("pos_y_out", want.y, pos_y_out);
                check_field("yaw_out", 32'(want.yaw), 32'(yaw_out));
                check_field("pitch_out", 32'(want.pitch), 32'(pitch_out));
                check_field("pos_saturated", 32'(want.sat), 32'(pos_saturated));
            end
        end
    end

    // Angle wrap and clamp cases, every sign combination but SIGN_M2 forward with SIGN_NEG right, and speed extremes.
    task automatic test_corners();
        send_cmd(17'sd0, 17'sd0, SIGN_ZERO, SIGN_ZERO, 16'sd0);
        send_cmd(17'sd46080, -17'sd65536, SIGN_POS, SIGN_ZERO, SPEED_MAX);
        send_cmd(-17'sd46080, 17'sd46080, SIGN_POS, SIGN_POS, SPEED_MIN);
        send_cmd(17'sd65535, 17'sd65535, SIGN_POS, SIGN_NEG, 16'sd256);
        send_cmd(-17'sd65536, -17'sd46080, SIGN_ZERO, SIGN_POS, SPEED_MAX);
        send_cmd(17'sd1, -17'sd1, SIGN_ZERO, SIGN_NEG, SPEED_MAX);
        send_cmd(17'sd0, 17'sd1, SIGN_NEG, SIGN_ZERO, SPEED_MAX);
        send_cmd(17'sd0, 17'sd0, SIGN_NEG, SIGN_POS, SPEED_MIN);
        send_cmd(17'sd0, 17'sd0, SIGN_NEG, SIGN_NEG, 16'sd1);
        send_cmd(17'sd0, 17'sd3000, SIGN_M2, SIGN_ZERO, -16'sd1);
        send_cmd(17'sd0, 17'sd0, SIGN_ZERO, SIGN_M2, 16'sd100);
        send_cmd(17'sd0, 17'sd0, SIGN_M2, SIGN_M2, 16'sd12345);
        send_cmd(17'sd0, 17'sd0, SIGN_POS, SIGN_M2, -16'sd12345);
        send_cmd(17'sd0, 17'sd0, SIGN_M2, SIGN_POS, SPEED_MAX);
        send_cmd(17'sd0, 17'sd5760, SIGN_ZERO, SIGN_ZERO, SPEED_MAX);
        send_cmd(17'sd0, 17'sd11520, SIGN_POS, SIGN_ZERO, 16'sd0);
        send_cmd(17'sd100, 17'sd1, SIGN_POS, SIGN_POS, 16'sd1);
        send_cmd(-17'sd100, 17'sd1, SIGN_NEG, SIGN_NEG, -16'sd1);
        send_cmd(17'sd23040, 17'sd23040, SIGN_POS, SIGN_ZERO, 16'sh4000);
        send_cmd(-17'sd23040, -17'sd46080, SIGN_POS, SIGN_ZERO, SPEED_MIN);
        send_cmd(17'sd0, 17'sd0, SIGN_NEG, SIGN_M2, SPEED_MIN);
    endtask

    // Long straight runs drive the position into both y bounds and the upper x bound.
    task automatic test_position_bounds();
        int k;
        send_cmd(17'sd0, 17'(-yaw_now), SIGN_ZERO, SIGN_ZERO, 16'sd0);
        for (k = 0; k < 270; k++)
            send_cmd(17'(int'($urandom_range(0, 400)) - 200), 17'sd0, SIGN_POS, SIGN_ZERO,
                     SPEED_MAX);
        steady = 1'b1;
        for (k = 0; k < 270; k++)
            send_cmd(17'sd0, 17'sd0, SIGN_ZERO, SIGN_POS, SPEED_MAX);
        steady = 1'b0;
        for (k = 0; k < 540; k++)
            send_cmd(17'sd0, 17'sd0, SIGN_NEG, SIGN_ZERO, SPEED_MAX);
    endtask

    // Random motion commands; the first stretch runs without any idling.
    task automatic test_random_moves();
        int k;
        int pick;
        logic signed [15:0] spd;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = (k < 200);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                spd = 16'($urandom());
            else if (pick < 60)
                spd = 16'sd0;
            else if (pick < 75)
                spd = ($urandom_range(0, 1) == 0) ? SPEED_MAX : SPEED_MIN;
            else
                spd = 16'(int'($urandom_range(0, 1024)) - 512);
            send_cmd(rand_angle_delta(), rand_angle_delta(), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), spd);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int k;
        // Full-circle sine table, built from one quarter by symmetry.
        for (k = 0; k < LUT_N; k++)
        begin
            unique case (k / (LUT_N / 4))
                0: sine_lut[k] = quarter_sine_q15(k % (LUT_N / 4));
                1: sine_lut[k] = quarter_sine_q15(LUT_N / 4 - k % (LUT_N / 4));
                2: sine_lut[k] = -quarter_sine_q15(k % (LUT_N / 4));
                default: sine_lut[k] = -quarter_sine_q15(LUT_N / 4 - k % (LUT_N / 4));
            endcase
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_position_bounds();
        test_random_moves();
        in_valid <= 1'b0;

        // Wait for every pose still owed, then keep watching for stray results.
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("heading_pose_integrator_top_tb: clean");
        else
            $display("heading_pose_integrator_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
